>>> sv/skmh_pkg.sv
// Package for the SipHash-2-4 keyed message hash: item types, constants
// and the SipRound / compression functions. No dependencies.
`timescale 1ns / 1ps

package skmh_pkg;

   localparam int WORD_WIDTH      = 64;
   localparam int COUNT_WIDTH     = 4;
   localparam int LEN_WIDTH       = 8;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_LOW  = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_HIGH = 1'b1;

   localparam logic [WORD_WIDTH-1:0] SIP_C0 = 64'h736f6d6570736575;
   localparam logic [WORD_WIDTH-1:0] SIP_C1 = 64'h646f72616e646f6d;
   localparam logic [WORD_WIDTH-1:0] SIP_C2 = 64'h6c7967656e657261;
   localparam logic [WORD_WIDTH-1:0] SIP_C3 = 64'h7465646279746573;
   localparam logic [WORD_WIDTH-1:0] SIP_FINAL_XOR = 64'h00000000000000ff;
   localparam int SIP_LEN_SHIFT = 56;

   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = 4'd8;

   typedef struct packed {
      logic [WORD_WIDTH-1:0]  msg_word;
      logic [COUNT_WIDTH-1:0] valid_bytes;
      logic                   last;
   } req_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] hash_value;
      logic                  framing_error;
   } rsp_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] v0;
      logic [WORD_WIDTH-1:0] v1;
      logic [WORD_WIDTH-1:0] v2;
      logic [WORD_WIDTH-1:0] v3;
   } vstate_type;

   // item handed to the finalization pipe
   typedef struct packed {
      vstate_type            v;
      logic [WORD_WIDTH-1:0] block;
      logic                  err;
   } fin_type;

   function automatic vstate_type sip_round(input vstate_type s);
      vstate_type r;
      r = s;
      r.v0 = r.v0 + r.v1;
      r.v1 = {r.v1[50:0], r.v1[63:51]} ^ r.v0;
      r.v0 = {r.v0[31:0], r.v0[63:32]};
      r.v2 = r.v2 + r.v3;
      r.v3 = {r.v3[47:0], r.v3[63:48]} ^ r.v2;
      r.v0 = r.v0 + r.v3;
      r.v3 = {r.v3[42:0], r.v3[63:43]} ^ r.v0;
      r.v2 = r.v2 + r.v1;
      r.v1 = {r.v1[46:0], r.v1[63:47]} ^ r.v2;
      r.v2 = {r.v2[31:0], r.v2[63:32]};
      return r;
   endfunction

   function automatic vstate_type sip_compress(input vstate_type s,
                                               input logic [WORD_WIDTH-1:0] m);
      vstate_type r;
      r = s;
      r.v3 = r.v3 ^ m;
      r = sip_round(sip_round(r));
      r.v0 = r.v0 ^ m;
      return r;
   endfunction

endpackage

>>> sv/siphash_keyed_message_hash.sv
// SipHash-2-4 keyed message hash. Takes one 64-bit message word per cycle while
// req_ready is high and returns one result item per message (hash or framing
// error). An item enters an input register; the next cycle it is folded into the
// v0..v3 state with two unrolled SipRounds, which is the feedback loop that sets
// the rate of one word per clock. The last item of a message, or a short item
// that aborts it, then runs through a four-register finalization pipe (f1, f2,
// f3 and the output register) before its result is offered; rsp_ready held low
// backs up through the pipe to req_ready. The key registers are sampled at the
// first item of each message.
`timescale 1ns / 1ps

module siphash_keyed_message_hash (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  skmh_pkg::req_type                        req_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output skmh_pkg::rsp_type                        rsp_data,
   input  logic                                     csr_write_en,
   input  logic [skmh_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [skmh_pkg::WORD_WIDTH-1:0]          csr_wdata
);

   logic [skmh_pkg::WORD_WIDTH-1:0]  key_low_ff, key_high_ff;
   logic                             s0_v_ff;
   skmh_pkg::req_type                s0_ff;
   skmh_pkg::vstate_type             v_ff, v_in;
   logic [skmh_pkg::LEN_WIDTH-1:0]   len_ff, len_in;
   logic                             in_msg_ff, in_msg_in;

   skmh_pkg::vstate_type             v_cur, v_cmp;
   logic [skmh_pkg::LEN_WIDTH-1:0]   len_cur;
   logic [skmh_pkg::COUNT_WIDTH-1:0] cnt;
   logic                             full, s0_emit, s0_go;
   logic [skmh_pkg::WORD_WIDTH-1:0]  tail;
   skmh_pkg::fin_type                fin_item;
   logic                             fin_valid, fin_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            skmh_pkg::CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
            skmh_pkg::CSR_KEY_HIGH: key_high_ff <= csr_wdata;
            default:                key_low_ff  <= key_low_ff;
         endcase
      end
   end

   always_comb begin
      full = s0_ff.valid_bytes >= skmh_pkg::FULL_COUNT;
      cnt  = full ? skmh_pkg::FULL_COUNT : s0_ff.valid_bytes;

      if (in_msg_ff) begin
         v_cur   = v_ff;
         len_cur = len_ff;
      end else begin
         v_cur.v0 = key_low_ff ^ skmh_pkg::SIP_C0;
         v_cur.v1 = key_high_ff ^ skmh_pkg::SIP_C1;
         v_cur.v2 = key_low_ff ^ skmh_pkg::SIP_C2;
         v_cur.v3 = key_high_ff ^ skmh_pkg::SIP_C3;
         len_cur  = '0;
      end

      v_cmp  = skmh_pkg::sip_compress(v_cur, s0_ff.msg_word);
      len_in = len_cur + {4'h0, cnt};

      for (int i = 0; i < 8; i++) begin
         tail[8*i +: 8] = (4'(i) < cnt) ? s0_ff.msg_word[8*i +: 8] : 8'h00;
      end

      fin_item.v     = full ? v_cmp : v_cur;
      fin_item.block = {len_in, {skmh_pkg::SIP_LEN_SHIFT{1'b0}}}
                       | (full ? '0 : tail);
      fin_item.err   = !s0_ff.last;

      s0_emit   = s0_ff.last || !full;
      fin_valid = s0_v_ff && s0_emit;
      s0_go     = s0_v_ff && (!s0_emit || fin_ready);
      req_ready = !s0_v_ff || s0_go;

      v_in      = v_cmp;
      in_msg_in = !s0_emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff   <= 1'b0;
         in_msg_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            s0_v_ff <= req_valid;
         end
         if (s0_go) begin
            in_msg_ff <= in_msg_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s0_ff <= req_data;
      end
      if (s0_go && !s0_emit) begin
         v_ff   <= v_in;
         len_ff <= len_in;
      end
   end

   skmh_fin_pipe u_fin (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fin_valid),
      .in_ready  (fin_ready),
      .in_item   (fin_item),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      s0_go && s0_ff.last |=> !in_msg_ff)
      else $error("last item left the message open");

   a_short_aborts: assert property (@(posedge clock) disable iff (reset)
      s0_go && !s0_ff.last && !full |=> !in_msg_ff)
      else $error("short item did not abort the message");

   a_full_opens: assert property (@(posedge clock) disable iff (reset)
      s0_go && !s0_ff.last && full |=> in_msg_ff)
      else $error("full word did not keep the message open");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s0_v_ff && s0_emit && !fin_ready)
      else $error("input stalled without a blocked item");
`endif

endmodule

>>> sv/skmh_fin_pipe.sv
// Finalization pipe: compresses the final block, then the four closing
// SipRounds over two stages, and holds the result item. Uses skmh_pkg.
`timescale 1ns / 1ps

module skmh_fin_pipe (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  skmh_pkg::fin_type  in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output skmh_pkg::rsp_type  out_item
);

   typedef struct packed {
      skmh_pkg::vstate_type v;
      logic                 err;
   } stage_type;

   logic               f1_v_ff, f2_v_ff, f3_v_ff, out_v_ff;
   skmh_pkg::fin_type  f1_ff;
   stage_type          f2_ff, f3_ff;
   skmh_pkg::rsp_type  out_ff;

   logic               f1_rdy, f2_rdy, f3_rdy, out_rdy;
   stage_type          f2_in, f3_in;
   skmh_pkg::vstate_type v_last;
   skmh_pkg::rsp_type  out_in;

   assign out_rdy  = !out_v_ff || out_ready;
   assign f3_rdy   = !f3_v_ff || out_rdy;
   assign f2_rdy   = !f2_v_ff || f3_rdy;
   assign f1_rdy   = !f1_v_ff || f2_rdy;
   assign in_ready = f1_rdy;

   always_comb begin
      f2_in.v   = skmh_pkg::sip_compress(f1_ff.v, f1_ff.block);
      f2_in.v.v2 = f2_in.v.v2 ^ skmh_pkg::SIP_FINAL_XOR;
      f2_in.err = f1_ff.err;

      f3_in.v   = skmh_pkg::sip_round(skmh_pkg::sip_round(f2_ff.v));
      f3_in.err = f2_ff.err;

      v_last = skmh_pkg::sip_round(skmh_pkg::sip_round(f3_ff.v));
      out_in.framing_error = f3_ff.err;
      out_in.hash_value    = f3_ff.err ? '0 : (v_last.v0 ^ v_last.v1 ^ v_last.v2 ^ v_last.v3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff  <= 1'b0;
         f2_v_ff  <= 1'b0;
         f3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (f1_rdy) begin
            f1_v_ff <= in_valid;
         end
         if (f2_rdy) begin
            f2_v_ff <= f1_v_ff;
         end
         if (f3_rdy) begin
            f3_v_ff <= f2_v_ff;
         end
         if (out_rdy) begin
            out_v_ff <= f3_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && f1_rdy) begin
         f1_ff <= in_item;
      end
      if (f1_v_ff && f2_rdy) begin
         f2_ff <= f2_in;
      end
      if (f2_v_ff && f3_rdy) begin
         f3_ff <= f3_in;
      end
      if (f3_v_ff && out_rdy) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = out_v_ff;
   assign out_item  = out_ff;

`ifndef NO_ASSERTIONS
   a_err_zero_hash: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_ff.framing_error |-> out_ff.hash_value == '0)
      else $error("error item carries a nonzero hash");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      f3_v_ff && !out_rdy |=> f3_v_ff && out_v_ff)
      else $error("stalled stage lost its item");
`endif

endmodule
